### hw/rtl/sra_pkg.sv
// shared types and constants of the segment reassembly checker
// no dependencies; used by every rtl file of the block except sra_checker
package sra_pkg;

  // segment header layout
  localparam int unsigned HEADER_BYTES = 5;
  localparam int unsigned POS_W        = 17;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // input word kinds carried on tuser
  localparam logic ACT_SEG     = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  // configuration register indexes
  localparam logic CFG_MAX_LEN = 1'b0;
  localparam logic CFG_BIG_END = 1'b1;

  // segment completion status
  typedef enum logic [1:0] {
    ST_FAIL = 2'd0,
    ST_CONT = 2'd1,
    ST_LAST = 2'd2
  } status_t;

  // classified word handed from the front to the back
  typedef struct packed {
    logic        wr_valid;
    logic [15:0] base;
    logic [15:0] pos;
    logic [7:0]  data;
    logic        done;
    status_t     status;
    logic [7:0]  next_index;
    logic [15:0] next_offset;
  } sra_op_t;

  // decode a 16-bit header word from two consecutive bytes
  function automatic logic [15:0] hdr_word(input logic [7:0] first,
                                           input logic [7:0] second,
                                           input logic       big_end);
    hdr_word = big_end ? {first, second} : {second, first};
  endfunction

endpackage

### hw/rtl/segment_reassembly_checker_unit.sv
// Segment reassembly checker, top level.
// Input stream: one received segment byte per word. in_tdata carries the byte,
// in_tlast marks the final byte of a segment, in_tuser set means restart
// reassembly at index 0, offset 0 (in_tdata ignored).
// Each segment opens with a 5-byte header (more-flag/index, offset, length);
// index, offset and total size are checked and payload bytes come out as
// buffer writes at offset plus position while they stream in.
// Output stream: exactly one word per input word, in order. out_tuser set
// means a payload write; out_tlast marks a segment end with a valid status.
// Config port: cfg_index 0 max segment length, 1 header word byte order;
// written any cycle, takes effect for the next input word.
// Throughput: one word per cycle, sustained while out_tready stays high; the front end
// updates all header and sequence state as each byte is accepted.
// Path: an accepted word is written into the queue, then into the output register
// where the write address add sits; out_tvalid rises once the word is held there.
// Reset: sync active-low rst_n; sequence state clears, max length 1024,
// big-endian header words, queue and output empty.
// Stall: with out_tready low, the queue fills and in_tready drops once it
// holds QUEUE_DEPTH words; no word is lost.
// depends on sra_pkg, sra_front, sra_fifo, sra_back
module segment_reassembly_checker_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] seg_byte
  input  logic        in_tlast,
  input  logic        in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [15:0] write_addr, [23:16] write_data, [25:24] status,
                                  // [33:26] next_index, [49:34] next_offset, [55:50] zero
  output logic        out_tlast,  // done_valid
  output logic        out_tuser   // [0] write_valid
);

  sra_pkg::sra_op_t front_op, back_op;
  logic             q_full, q_empty, q_pop, in_fire;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  sra_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .in_action (in_tuser),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .op        (front_op)
  );

  sra_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_fire),
    .push_op (front_op),
    .pop     (q_pop),
    .pop_op  (back_op),
    .full    (q_full),
    .empty   (q_empty)
  );

  sra_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_op       (back_op),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

### hw/rtl/sra_front.sv
// front end: accepts segment words, checks the header, tracks expected index/offset
// depends on sra_pkg
module sra_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_fire,
  input  logic                in_action,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output sra_pkg::sra_op_t    op
);

  localparam int unsigned PW = sra_pkg::POS_W;
  localparam int unsigned HB = sra_pkg::HEADER_BYTES;

  logic [15:0]   max_len_r;
  logic          big_end_r;
  logic [7:0]    idx_r, idx_nxt;
  logic [15:0]   off_r, off_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          err_r, err_nxt;
  logic [7:0]    hdr_r   [HB];
  logic [7:0]    hdr_nxt [HB];
  logic [7:0]    hdr_upd [HB];

  logic          in_hdr;
  logic [15:0]   off_w, len_w;
  logic          chk_err, seg_err;
  logic [PW-1:0] q, pos_inc;
  logic          wr, end_ok;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= 16'd1024;
      big_end_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        sra_pkg::CFG_MAX_LEN: max_len_r <= cfg_data;
        sra_pkg::CFG_BIG_END: big_end_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // header capture for the current word
  always_comb begin
    in_hdr = pos_r < PW'(HB);
    for (int i = 0; i < HB; i++) begin
      hdr_upd[i] = (in_hdr && pos_r == PW'(i)) ? in_byte : hdr_r[i];
    end
    off_w = sra_pkg::hdr_word(hdr_upd[1], hdr_upd[2], big_end_r);
    len_w = sra_pkg::hdr_word(hdr_upd[3], hdr_upd[4], big_end_r);
  end

  // header checks, payload classification and end-of-segment decision
  always_comb begin
    chk_err = in_hdr && (
      (pos_r == PW'(0) && {1'b0, in_byte[7:1]} != idx_r) ||
      (pos_r == PW'(2) && off_w != off_r) ||
      (pos_r == PW'(4) && (17'(HB) + {1'b0, len_w}) > {1'b0, max_len_r}));
    seg_err = err_r | chk_err;
    q       = pos_r - PW'(HB);
    wr      = !in_hdr && !err_r && (q < {1'b0, len_w});
    pos_inc = (pos_r == sra_pkg::POS_MAX) ? pos_r : pos_r + PW'(1);
    end_ok  = !seg_err && (pos_r >= PW'(HB - 1)) &&
              (({1'b0, pos_r} + 18'd1) == (18'(HB) + {2'b0, len_w}));

    hdr_nxt        = hdr_upd;
    pos_nxt        = pos_inc;
    err_nxt        = seg_err;
    idx_nxt        = idx_r;
    off_nxt        = off_r;
    op.wr_valid    = wr;
    op.base        = off_w;
    op.pos         = q[15:0];
    op.data        = wr ? in_byte : 8'd0;
    op.done        = 1'b0;
    op.status      = sra_pkg::ST_FAIL;

    if (in_action == sra_pkg::ACT_RESTART) begin
      idx_nxt     = 8'd0;
      off_nxt     = 16'd0;
      pos_nxt     = '0;
      err_nxt     = 1'b0;
      for (int i = 0; i < HB; i++) hdr_nxt[i] = 8'd0;
      op.wr_valid = 1'b0;
      op.data     = 8'd0;
    end else if (in_last) begin
      op.done = 1'b1;
      if (end_ok) begin
        op.status = hdr_upd[0][0] ? sra_pkg::ST_CONT : sra_pkg::ST_LAST;
        idx_nxt   = idx_r + 8'd1;
        off_nxt   = off_r + len_w;
      end
      pos_nxt = '0;
      err_nxt = 1'b0;
      for (int i = 0; i < HB; i++) hdr_nxt[i] = 8'd0;
    end

    op.next_index  = idx_nxt;
    op.next_offset = off_nxt;
  end

  // segment state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 8'd0;
      off_r <= 16'd0;
      pos_r <= '0;
      err_r <= 1'b0;
      for (int i = 0; i < HB; i++) hdr_r[i] <= 8'd0;
    end else if (in_fire) begin
      idx_r <= idx_nxt;
      off_r <= off_nxt;
      pos_r <= pos_nxt;
      err_r <= err_nxt;
      for (int i = 0; i < HB; i++) hdr_r[i] <= hdr_nxt[i];
    end
  end

endmodule

### hw/rtl/sra_fifo.sv
// short queue of classified words between front and back
// depends on sra_pkg
module sra_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sra_pkg::sra_op_t push_op,
  input  logic             pop,
  output sra_pkg::sra_op_t pop_op,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sra_pkg::sra_op_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = cnt_r == CNT_W'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_op  = mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_op;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop)      cnt_r <= cnt_r + CNT_W'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule

### hw/rtl/sra_back.sv
// back end: forms the buffer write address and holds the output word
// depends on sra_pkg
module sra_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  sra_pkg::sra_op_t q_op,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [55:0]      out_tdata,
  output logic             out_tlast,
  output logic             out_tuser
);

  logic          valid_r;
  logic          wv_r;
  logic [15:0]   addr_r;
  logic [7:0]    data_r;
  logic          done_r;
  logic [1:0]    status_r;
  logic [7:0]    nidx_r;
  logic [15:0]   noff_r;

  assign q_pop = !q_empty && (!valid_r || out_tready);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      wv_r     <= q_op.wr_valid;
      addr_r   <= q_op.wr_valid ? q_op.base + q_op.pos : 16'd0;
      data_r   <= q_op.data;
      done_r   <= q_op.done;
      status_r <= q_op.status;
      nidx_r   <= q_op.next_index;
      noff_r   <= q_op.next_offset;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tlast  = done_r;
  assign out_tuser  = wv_r;
  assign out_tdata  = {6'd0, noff_r, nidx_r, status_r, data_r, addr_r};

endmodule

### hw/rtl/sra_checker.sv
// port-level checks of the segment reassembly checker, bound to the top level
// depends on segment_reassembly_checker_unit ports only
module sra_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tlast) && $stable(out_tuser))
    else $error("output word changed while stalled");

  // no write means zero address and data
  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[23:0] == 24'd0)
    else $error("address or data set without a write");

  // status only at segment end
  a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[25:24] == 2'd0)
    else $error("status set outside segment end");

  // status code 3 is never produced
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[25:24] != 2'd3)
    else $error("undefined status code");

  // pad bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[55:50] == 6'd0)
    else $error("pad bits of output word set");

endmodule

bind segment_reassembly_checker_unit sra_checker u_sra_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
